// ===== design/ewfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the window locate function for the frame scanner.
// No dependencies; every other design file except the checker imports this package.
package ewfs_pkg;

  localparam int PanelWidth   = 104;
  localparam int PanelHeight  = 212;
  localparam int GroupsPerRow = (PanelWidth + 7) / 8;

  localparam int PaddrW     = 5;
  localparam int ApbDataW   = 32;
  localparam int SDataW     = 16;
  localparam int MDataW     = 32;
  localparam int IdxW       = 14;
  localparam int RowW       = 8;
  localparam int ColW       = 5;

  localparam logic [6:0] WinWReset = 7'd104;
  localparam logic [7:0] WinHReset = 8'd212;

  localparam logic [7:0] ByteOutside = 8'hFF;

  // Each bit of a nibble doubled into two adjacent bits
  localparam logic [7:0] NibbleDouble [16] = '{
    8'h00, 8'h03, 8'h0C, 8'h0F, 8'h30, 8'h33, 8'h3C, 8'h3F,
    8'hC0, 8'hC3, 8'hCC, 8'hCF, 8'hF0, 8'hF3, 8'hFC, 8'hFF
  };

  typedef enum logic {
    FuncBegin   = 1'b0,
    FuncDeliver = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    RegWinX   = 3'd0,
    RegWinY   = 3'd1,
    RegWinW   = 3'd2,
    RegWinH   = 3'd3,
    RegInvert = 3'd4,
    RegMirror = 3'd5,
    RegGrey   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] win_x;
    logic [7:0] win_y;
    logic [6:0] win_w;
    logic [7:0] win_h;
    logic       invert_data;
    logic       mirror_rows;
    logic       grey_mode;
  } cfg_t;

  typedef struct packed {
    logic            in_win;
    logic [IdxW-1:0] idx;
  } loc_t;

  // One classified item waiting for formatting
  typedef struct packed {
    logic            valid;
    logic            in_win;
    logic            invert;
    logic            grey;
    logic [7:0]      first;
    logic [7:0]      second;
    logic [IdxW-1:0] nidx;
    logic            ninside;
    logic            last;
  } entry_t;

  function automatic loc_t locate(logic [RowW-1:0] row, logic [ColW-1:0] grp, cfg_t c);
    logic [7:0]  w;
    logic [7:0]  h;
    logic [4:0]  wb;
    logic [7:0]  x;
    logic [7:0]  j;
    logic [8:0]  xe;
    logic [8:0]  ye;
    logic [7:0]  r;
    logic [7:0]  dj;
    logic [12:0] prod;
    loc_t        res;
    w  = ({1'b0, c.win_w} > 8'(PanelWidth)) ? 8'(PanelWidth) : {1'b0, c.win_w};
    h  = (c.win_h > 8'(PanelHeight)) ? 8'(PanelHeight) : c.win_h;
    wb = 5'(({1'b0, w} + 9'd7) >> 3);
    x  = {c.win_x[7:3], 3'b000};
    j  = {grp, 3'b000};
    xe = {1'b0, x} + {1'b0, wb, 3'b000};
    ye = {1'b0, c.win_y} + {1'b0, h};
    res.in_win = (j >= x) && ({1'b0, j} < xe) && (row >= c.win_y) &&
                 ({1'b0, row} < ye);
    r = row - c.win_y;
    if (c.mirror_rows) begin
      r = (h - 8'd1) - r;
    end
    dj   = j - x;
    prod = 13'(r) * 13'(wb);
    if (c.grey_mode) begin
      res.idx = 14'(dj >> 2) + {prod, 1'b0};
    end else begin
      res.idx = 14'(dj >> 3) + {1'b0, prod};
    end
    if (!res.in_win) begin
      res.idx = '0;
    end
    return res;
  endfunction

endpackage

// ===== design/ewfs_regs.sv =====
`timescale 1ns / 1ps
// Configuration register bank behind the APB-style port.
// Depends on ewfs_pkg for the register map and cfg_t.
module ewfs_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ewfs_pkg::PaddrW-1:0]   paddr,
  input  logic [ewfs_pkg::ApbDataW-1:0] pwdata,
  output logic [ewfs_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output ewfs_pkg::cfg_t                cfg_o
);
  import ewfs_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        RegWinX:   cfg_d.win_x       = pwdata[7:0];
        RegWinY:   cfg_d.win_y       = pwdata[7:0];
        RegWinW:   cfg_d.win_w       = pwdata[6:0];
        RegWinH:   cfg_d.win_h       = pwdata[7:0];
        RegInvert: cfg_d.invert_data = pwdata[0];
        RegMirror: cfg_d.mirror_rows = pwdata[0];
        RegGrey:   cfg_d.grey_mode   = pwdata[0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegWinX:   prdata = {24'd0, cfg_q.win_x};
      RegWinY:   prdata = {24'd0, cfg_q.win_y};
      RegWinW:   prdata = {25'd0, cfg_q.win_w};
      RegWinH:   prdata = {24'd0, cfg_q.win_h};
      RegInvert: prdata = {31'd0, cfg_q.invert_data};
      RegMirror: prdata = {31'd0, cfg_q.mirror_rows};
      RegGrey:   prdata = {31'd0, cfg_q.grey_mode};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_x       <= '0;
      cfg_q.win_y       <= '0;
      cfg_q.win_w       <= WinWReset;
      cfg_q.win_h       <= WinHReset;
      cfg_q.invert_data <= 1'b0;
      cfg_q.mirror_rows <= 1'b0;
      cfg_q.grey_mode   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/ewfs_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, walks the row and column-group counters and
// classifies each position against the window. Depends on ewfs_pkg.
module ewfs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ewfs_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [7:0]          first_i,
  input  logic [7:0]          second_i,
  output logic                push_o,
  output ewfs_pkg::entry_t    entry_o,
  input  logic                full_i
);
  import ewfs_pkg::*;

  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            active_q, active_d;

  logic            accept;
  logic            wrap;
  logic [ColW-1:0] col_adv;
  logic [RowW:0]   row_adv;
  logic            frame_end;
  loc_t            cur_loc;
  loc_t            nxt_loc;
  loc_t            org_loc;
  entry_t          entry;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept;

  always_comb begin
    wrap      = ({1'b0, col_q} + 6'd1) >= 6'(GroupsPerRow);
    col_adv   = wrap ? '0 : col_q + 5'd1;
    row_adv   = wrap ? {1'b0, row_q} + 9'd1 : {1'b0, row_q};
    frame_end = row_adv >= 9'(PanelHeight);
    cur_loc   = locate(row_q, col_q, cfg_i);
    nxt_loc   = locate(row_adv[RowW-1:0], col_adv, cfg_i);
    org_loc   = locate('0, '0, cfg_i);

    row_d    = row_q;
    col_d    = col_q;
    active_d = active_q;

    entry         = '0;
    entry.invert  = cfg_i.invert_data;
    entry.grey    = cfg_i.grey_mode;
    entry.first   = first_i;
    entry.second  = second_i;

    if (func_i == FuncBegin) begin
      row_d         = '0;
      col_d         = '0;
      active_d      = 1'b1;
      entry.nidx    = org_loc.idx;
      entry.ninside = org_loc.in_win;
    end else if (active_q) begin
      entry.valid  = 1'b1;
      entry.in_win = cur_loc.in_win;
      if (frame_end) begin
        row_d      = '0;
        col_d      = '0;
        active_d   = 1'b0;
        entry.last = 1'b1;
      end else begin
        row_d         = row_adv[RowW-1:0];
        col_d         = col_adv;
        entry.nidx    = nxt_loc.idx;
        entry.ninside = nxt_loc.in_win;
      end
    end
  end

  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      row_q    <= row_d;
      col_q    <= col_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== design/ewfs_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified items between front and back end.
// Depends on ewfs_pkg for entry_t.
module ewfs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ewfs_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output ewfs_pkg::entry_t entry_o,
  output logic             empty_o
);
  import ewfs_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign entry_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + 1'b1;
    rptr_d = rptr_q + 1'b1;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_d;
      end
      if (pop_i) begin
        rptr_q <= rptr_d;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/ewfs_back.sv =====
`timescale 1ns / 1ps
// Back end: forms the two panel bytes of each queued item and holds the
// result in the output register. Depends on ewfs_pkg for entry_t and tables.
module ewfs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ewfs_pkg::entry_t             entry_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ewfs_pkg::MDataW-1:0]  m_axis_tdata,
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast
);
  import ewfs_pkg::*;

  logic              vld_q, vld_d;
  logic [MDataW-1:0] data_q, data_d;
  logic              user_q, user_d;
  logic              last_q, last_d;
  logic              load;
  logic [7:0]        src_a;
  logic [7:0]        src_b;
  logic [7:0]        hi;
  logic [7:0]        lo;

  assign load  = ~empty_i & (~vld_q | m_axis_tready);
  assign pop_o = load;

  always_comb begin
    src_a = entry_i.invert ? ~entry_i.first  : entry_i.first;
    src_b = entry_i.invert ? ~entry_i.second : entry_i.second;
    if (!entry_i.valid) begin
      hi = '0;
      lo = '0;
    end else if (!entry_i.in_win) begin
      hi = ByteOutside;
      lo = ByteOutside;
    end else if (entry_i.grey) begin
      hi = src_a;
      lo = src_b;
    end else begin
      hi = NibbleDouble[src_a[7:4]];
      lo = NibbleDouble[src_a[3:0]];
    end
    data_d = {1'b0, entry_i.ninside, entry_i.nidx, lo, hi};
    user_d = entry_i.valid;
    last_d = entry_i.last;
    vld_d  = load | (vld_q & ~m_axis_tready);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      user_q <= user_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

// ===== design/epaper_window_frame_scanner_top.sv =====
`timescale 1ns / 1ps
// Top level of the e-paper window frame scanner: register bank, front end,
// item queue and back end. Depends on ewfs_pkg and the four ewfs_* modules.
//
//  channel  | direction | tdata / fields                         | tuser       | tlast
//  s_axis   | in        | [7:0] src_first, [15:8] src_second     | func        | -
//  m_axis   | out       | [7:0] panel_hi, [15:8] panel_lo,       | panel_valid | frame_last
//           |           | [29:16] next_index, [30] next_inside   |             |
//  apb      | in        | 7 registers at byte address 4*index    | -           | -
//
// One item per cycle sustained while m_axis_tready stays high; an accepted item is
// written to the queue, then loaded into the output register.
// The front end takes an item whenever the two-entry queue has room, so input
// keeps flowing while a result waits in the output register.
// Reset clears the counters, the queue and the output valid; registers return
// to a full-panel window in black-white mode.
module epaper_window_frame_scanner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ewfs_pkg::SDataW-1:0]   s_axis_tdata,  // [7:0] src_first, [15:8] src_second
  input  logic                          s_axis_tuser,  // [0] func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ewfs_pkg::MDataW-1:0]   m_axis_tdata,  // [7:0] panel_hi, [15:8] panel_lo,
                                                       // [29:16] next_index, [30] next_inside
  output logic                          m_axis_tuser,  // [0] panel_valid
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ewfs_pkg::PaddrW-1:0]   paddr,
  input  logic [ewfs_pkg::ApbDataW-1:0] pwdata,
  output logic [ewfs_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import ewfs_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t pop_entry;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  ewfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ewfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .first_i    (s_axis_tdata[7:0]),
    .second_i   (s_axis_tdata[15:8]),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  ewfs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  ewfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (pop_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/ewfs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the scanner's result stream, bound to the top level.
// Depends only on the top level's port names.
module ewfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled result
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No panel bytes without panel_valid
  a_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0 && !m_axis_tlast)
    else $error("panel bytes or frame end on a non-panel result");

  // Frame end carries a panel group and announces nothing
  a_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser && m_axis_tdata[30:16] == 15'd0)
    else $error("frame end with a pending index");

  // An index outside the window reads as zero
  a_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[30] |-> m_axis_tdata[29:16] == 14'd0)
    else $error("index reported for a position outside the window");

endmodule

bind epaper_window_frame_scanner_top ewfs_checker u_ewfs_checker (.*);
